/* rtl/core/av_pair_mic_flag_editor_assert.svh */
// assertion macros for the flag editor checker
`ifndef AV_PAIR_MIC_FLAG_EDITOR_ASSERT_SVH
`define AV_PAIR_MIC_FLAG_EDITOR_ASSERT_SVH

// clocked check, off while reset is held
`define AVPME_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also runs during reset
`define AVPME_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/core/avpme_pkg.sv */
`timescale 1ns / 1ps
package avpme_pkg;

    localparam int unsigned MAX_LIST_BYTES_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH_DEF    = 4;

    localparam int unsigned CAP_W = 11;
    localparam int unsigned LEN_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1032;

    localparam logic [15:0] ID_END    = 16'h0000;
    localparam logic [15:0] ID_FLAGS  = 16'h0006;
    localparam logic [15:0] LEN_FLAGS = 16'h0004;
    localparam logic [7:0]  MIC_BIT   = 8'h02;

    localparam logic [7:0] PAIR_ID_LO  = 8'h06;
    localparam logic [7:0] PAIR_LEN_LO = 8'h04;
    localparam logic [7:0] PAIR_FLAGS  = 8'h02;

    localparam logic [2:0] PAIR_IDX_ID    = 3'd0;
    localparam logic [2:0] PAIR_IDX_LEN   = 3'd2;
    localparam logic [2:0] PAIR_IDX_FLAGS = 3'd4;
    localparam logic [2:0] PAIR_IDX_LAST  = 3'd7;

    // one request from front to back: everything a single input byte emits
    typedef struct packed {
        logic             pop_en;
        logic [7:0]       pop_byte;
        logic             pair_mid;
        logic [2:0]       flush_cnt;
        logic [3:0][7:0]  flush_bytes;
        logic             pair_tail;
        logic             fin;
        logic             status;
        logic [LEN_W-1:0] length;
        logic             inserted;
    } t_cmd;

    function automatic logic [7:0] pair_byte(logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            PAIR_IDX_ID:    b = PAIR_ID_LO;
            PAIR_IDX_LEN:   b = PAIR_LEN_LO;
            PAIR_IDX_FLAGS: b = PAIR_FLAGS;
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/avpme_front.sv */
`timescale 1ns / 1ps
module avpme_front #(
    parameter int unsigned MAX_LIST_BYTES = avpme_pkg::MAX_LIST_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_byte,
    input  logic                         i_first,
    input  logic                         i_final,
    input  logic [avpme_pkg::CAP_W-1:0]  i_capacity,
    input  logic                         i_q_ready,
    output logic                         o_q_push,
    output avpme_pkg::t_cmd              o_q_cmd
);
    import avpme_pkg::*;

    localparam int unsigned BP_W  = $clog2(MAX_LIST_BYTES + 2);
    localparam int unsigned TOT_W = (BP_W + 1 > LEN_W) ? BP_W + 1 : LEN_W;
    localparam logic [BP_W-1:0] MAX_BP = BP_W'(MAX_LIST_BYTES);

    typedef enum logic [1:0] {
        WK_HEADER,
        WK_VALUE,
        WK_DONE
    } t_walk;

    logic [3:0][7:0] r_win;
    logic [2:0]      r_fill;
    t_walk           r_phase;
    logic [15:0]     r_vbl;
    logic            r_pending;
    logic            r_found;
    logic            r_done;
    logic [BP_W-1:0] r_bp;

    logic [3:0][7:0] e_win,     n_win;
    logic [2:0]      e_fill,    n_fill;
    t_walk           e_phase,   n_phase;
    logic [15:0]     e_vbl,     n_vbl;
    logic            e_pending, n_pending;
    logic            e_found,   n_found;
    logic            e_done,    n_done;
    logic [BP_W-1:0] e_bp,      n_bp;

    logic             accept;
    logic             pop;
    logic             mid;
    logic [15:0]      id;
    logic [15:0]      len;
    logic [TOT_W-1:0] total;
    logic             err;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        if (i_first) begin
            e_win     = '0;
            e_fill    = '0;
            e_phase   = WK_HEADER;
            e_vbl     = '0;
            e_pending = 1'b0;
            e_found   = 1'b0;
            e_done    = 1'b0;
            e_bp      = '0;
        end else begin
            e_win     = r_win;
            e_fill    = r_fill;
            e_phase   = r_phase;
            e_vbl     = r_vbl;
            e_pending = r_pending;
            e_found   = r_found;
            e_done    = r_done;
            e_bp      = r_bp;
        end

        pop = e_fill[2];
        n_win = e_win;
        if (pop) begin
            n_win = {i_byte, e_win[3], e_win[2], e_win[1]};
            n_fill = 3'd4;
        end else begin
            n_win[e_fill[1:0]] = i_byte;
            n_fill = e_fill + 3'd1;
        end
        n_bp = (e_bp <= MAX_BP) ? e_bp + BP_W'(1) : e_bp;

        id  = {n_win[1], n_win[0]};
        len = {n_win[3], n_win[2]};

        n_phase   = e_phase;
        n_vbl     = e_vbl;
        n_pending = e_pending;
        n_found   = e_found;
        n_done    = e_done;
        mid       = 1'b0;

        unique case (e_phase)
            WK_HEADER: begin
                if (e_vbl == 16'd3) begin
                    n_vbl = '0;
                    if (id == ID_END) begin
                        n_phase = WK_DONE;
                        n_done  = 1'b1;
                        mid     = !e_found;
                    end else if (len != 16'd0) begin
                        n_pending = (id == ID_FLAGS) && (len == LEN_FLAGS);
                        n_phase   = WK_VALUE;
                        n_vbl     = len;
                    end else begin
                        n_pending = 1'b0;
                    end
                end else begin
                    n_vbl = e_vbl + 16'd1;
                end
            end
            WK_VALUE: begin
                n_vbl = e_vbl - 16'd1;
                if (e_vbl == 16'd1) begin
                    if (e_pending) begin
                        n_win[0]  = n_win[0] | MIC_BIT;
                        n_found   = 1'b1;
                        n_pending = 1'b0;
                    end
                    n_phase = WK_HEADER;
                end
            end
            WK_DONE: begin
            end
            default: begin
            end
        endcase

        total = TOT_W'(n_bp) + (n_found ? TOT_W'(0) : TOT_W'(8));
        err   = (n_bp > MAX_BP) || (total > TOT_W'(i_capacity));

        o_q_cmd.pop_en      = pop;
        o_q_cmd.pop_byte    = e_win[0];
        o_q_cmd.pair_mid    = mid;
        o_q_cmd.flush_cnt   = i_final ? n_fill : 3'd0;
        o_q_cmd.flush_bytes = n_win;
        o_q_cmd.pair_tail   = i_final && !n_done && !n_found;
        o_q_cmd.fin         = i_final;
        o_q_cmd.status      = err;
        o_q_cmd.length      = err ? '0 : total[LEN_W-1:0];
        o_q_cmd.inserted    = !err && !n_found;

        o_q_push = accept && (pop || mid || i_final);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_final)) begin
            r_win     <= '0;
            r_fill    <= '0;
            r_phase   <= WK_HEADER;
            r_vbl     <= '0;
            r_pending <= 1'b0;
            r_found   <= 1'b0;
            r_done    <= 1'b0;
            r_bp      <= '0;
        end else if (accept) begin
            r_win     <= n_win;
            r_fill    <= n_fill;
            r_phase   <= n_phase;
            r_vbl     <= n_vbl;
            r_pending <= n_pending;
            r_found   <= n_found;
            r_done    <= n_done;
            r_bp      <= n_bp;
        end
    end

endmodule

/* rtl/core/avpme_queue.sv */
`timescale 1ns / 1ps
module avpme_queue #(
    parameter int unsigned DEPTH = avpme_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  avpme_pkg::t_cmd i_data,
    output logic            o_ready,
    output logic            o_valid,
    output avpme_pkg::t_cmd o_data,
    input  logic            i_pop
);
    import avpme_pkg::*;

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [IDX_W-1:0] r_wp;
    logic [IDX_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_cnt != FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + IDX_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_IDX) ? '0 : r_rp + IDX_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/avpme_back.sv */
`timescale 1ns / 1ps
module avpme_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  avpme_pkg::t_cmd             i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [7:0]                  o_byte,
    output logic                        o_end,
    output logic                        o_status,
    output logic [avpme_pkg::LEN_W-1:0] o_length,
    output logic                        o_inserted
);
    import avpme_pkg::*;

    typedef enum logic [1:0] {
        PH_POP,
        PH_MID,
        PH_FLUSH,
        PH_TAIL
    } t_ph;

    logic             r_busy;
    t_ph              r_ph;
    logic [2:0]       r_idx;
    t_cmd             r_cur;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;
    logic             r_out_status;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_ins;

    logic             n_busy;
    t_ph              n_ph;
    logic [2:0]       n_idx;
    t_cmd             n_cur;

    logic [3:0] en_cur;
    logic [3:0] en_head;
    logic [3:0] later;
    logic       has_later;
    logic       phase_end;
    logic       last_elem;
    logic       out_free;
    logic       adv;
    logic       load;
    logic [7:0] elem_byte;
    logic       elem_end;

    function automatic t_ph first_ph(logic [3:0] v);
        t_ph p;
        if (v[0]) begin
            p = PH_POP;
        end else if (v[1]) begin
            p = PH_MID;
        end else if (v[2]) begin
            p = PH_FLUSH;
        end else begin
            p = PH_TAIL;
        end
        return p;
    endfunction

    always_comb begin
        en_cur  = {r_cur.pair_tail, (r_cur.flush_cnt != 3'd0), r_cur.pair_mid, r_cur.pop_en};
        en_head = {i_q_cmd.pair_tail, (i_q_cmd.flush_cnt != 3'd0), i_q_cmd.pair_mid,
                   i_q_cmd.pop_en};
        later     = en_cur & (4'b1110 << r_ph);
        has_later = |later;

        unique case (r_ph)
            PH_POP: begin
                phase_end = 1'b1;
                elem_byte = r_cur.pop_byte;
            end
            PH_MID, PH_TAIL: begin
                phase_end = (r_idx == PAIR_IDX_LAST);
                elem_byte = pair_byte(r_idx);
            end
            PH_FLUSH: begin
                phase_end = (r_idx == r_cur.flush_cnt - 3'd1);
                elem_byte = r_cur.flush_bytes[r_idx[1:0]];
            end
        endcase

        last_elem = phase_end && !has_later;
        elem_end  = last_elem && r_cur.fin;
        out_free  = !r_out_valid || i_ready;
        adv       = r_busy && out_free;
        load      = i_q_valid && (!r_busy || (adv && last_elem));
        o_q_pop   = load;

        n_busy = r_busy;
        n_ph   = r_ph;
        n_idx  = r_idx;
        n_cur  = r_cur;
        if (load) begin
            n_busy = 1'b1;
            n_cur  = i_q_cmd;
            n_ph   = first_ph(en_head);
            n_idx  = '0;
        end else if (adv && last_elem) begin
            n_busy = 1'b0;
        end else if (adv) begin
            if (phase_end) begin
                n_ph  = first_ph(later);
                n_idx = '0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_ph        <= PH_POP;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_ph   <= n_ph;
            r_idx  <= n_idx;
            r_cur  <= n_cur;
            if (out_free) begin
                r_out_valid  <= r_busy;
                r_out_byte   <= elem_byte;
                r_out_end    <= elem_end;
                r_out_status <= elem_end && r_cur.status;
                r_out_len    <= elem_end ? r_cur.length : '0;
                r_out_ins    <= elem_end && r_cur.inserted;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_byte     = r_out_byte;
    assign o_end      = r_out_end;
    assign o_status   = r_out_status;
    assign o_length   = r_out_len;
    assign o_inserted = r_out_ins;

endmodule

/* rtl/core/av_pair_mic_flag_editor.sv */
`timescale 1ns / 1ps
// attribute-list editor: sets the mic bit in every complete flags pair and
// inserts a flags pair when the list has none
// s_axis: one raw list byte per request, tuser marks the first byte of a list,
//   tlast its last byte
// m_axis: one edited byte per request, tlast on the final byte of the list,
//   which also carries status, pair-inserted flag and total edited length
// apb: one register at address 0, the output capacity in bytes
// a byte leaves once four later bytes have arrived, or at the list's end;
//   it then goes through the command queue and the back-end registers
// one byte per cycle in while the queue has room, out while m_axis_tready
//   is high; the back-end sequencer emits an inserted pair as 8 bytes
//   and the end-of-list flush as up to 4; the queue absorbs those bursts
// reset sets the capacity to 1032 and clears the parser, the command queue
//   and the output register
// when m_axis_tready is low the output register holds, the command queue
//   fills, and s_axis_tready drops once it is full
module av_pair_mic_flag_editor #(
    parameter int unsigned MAX_LIST_BYTES = avpme_pkg::MAX_LIST_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH    = avpme_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic [0:0]  s_axis_tuser,   // in_first
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte, out_length, zero pad
    output logic [1:0]  m_axis_tuser,   // status, pair_inserted
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import avpme_pkg::*;

    logic [CAP_W-1:0] r_out_capacity;

    logic       q_push;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;
    t_cmd       q_in;
    t_cmd       q_out;

    logic [7:0]       out_byte;
    logic [LEN_W-1:0] out_len;
    logic             out_status;
    logic             out_ins;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - CAP_W){1'b0}}, r_out_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_out_capacity <= pwdata[CAP_W-1:0];
        end
    end

    avpme_front #(
        .MAX_LIST_BYTES (MAX_LIST_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_first    (s_axis_tuser[0]),
        .i_final    (s_axis_tlast),
        .i_capacity (r_out_capacity),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in)
    );

    avpme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    avpme_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (out_byte),
        .o_end      (m_axis_tlast),
        .o_status   (out_status),
        .o_length   (out_len),
        .o_inserted (out_ins)
    );

    assign m_axis_tdata = {{(24 - 8 - LEN_W){1'b0}}, out_len, out_byte};
    assign m_axis_tuser = {out_ins, out_status};

endmodule

/* rtl/core/avpme_checker.sv */
`timescale 1ns / 1ps
`include "av_pair_mic_flag_editor_assert.svh"
module avpme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic        out_mid;
    logic        out_err;
    logic        out_stall;
    logic [10:0] out_len;
    logic        out_summ;
    logic        out_len_ins;
    logic [26:0] out_word;

    assign out_mid     = m_axis_tvalid && !m_axis_tlast;
    assign out_err     = m_axis_tvalid && m_axis_tlast && m_axis_tuser[0];
    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_len     = m_axis_tdata[18:8];
    assign out_summ    = (m_axis_tuser != 2'b00) || (out_len != 11'd0);
    assign out_len_ins = (out_len != 11'd0) || m_axis_tuser[1];
    assign out_word    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

    `AVPME_CHECK_RST(a_idle_after_reset, !i_rst_n |=> !m_axis_tvalid, "valid after reset")

    `AVPME_CHECK(a_summary_only_at_end, out_mid |-> !out_summ, "summary before end of list")

    `AVPME_CHECK(a_error_clears_summary, out_err |-> !out_len_ins, "error with length or insert")

    `AVPME_CHECK(a_stall_holds, out_stall |=> (m_axis_tvalid && $stable(out_word)), "stall broken")

endmodule

bind av_pair_mic_flag_editor avpme_checker u_avpme_checker (.*);

/* tb/tb_av_pair_mic_flag_editor.sv */
`timescale 1ns / 1ps
module tb_av_pair_mic_flag_editor;
    import avpme_pkg::*;

    localparam int REG_OUT_CAPACITY = 0;
    localparam logic [2:0] ADDR_OUT_CAPACITY = 3'(4 * REG_OUT_CAPACITY);
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef enum logic [1:0] {WALK_HEADER, WALK_VALUE, WALK_DONE} walk_t;
    typedef enum int {LK_ENDED, LK_OPEN_TAIL, LK_CUT, LK_NOISE, LK_RESTART} list_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } list_req_t;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             err;
        logic [LEN_W-1:0] len;
        logic             ins;
    } edited_t;

    typedef struct packed {
        list_req_t        req;
        logic             typed;
        logic             err;
        logic [LEN_W-1:0] len;
        logic             ins;
        logic             cfg;
        logic [CAP_W-1:0] cap;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    av_pair_mic_flag_editor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // editor state mirror
    logic [7:0]       win [4];
    int               win_fill;
    walk_t            walk;
    logic [15:0]      bytes_left;
    logic             pend_flags;
    logic             have_flags;
    logic             end_seen;
    int               list_pos;
    logic [CAP_W-1:0] cap;

    edited_t   edited_q [$];
    list_req_t pend_reqs [$];
    logic [7:0] body [$];
    dir_row_t  dir_tab [$];
    logic             next_cfg = 1'b0;
    logic [CAP_W-1:0] next_cap = '0;

    int n_bad = 0;
    bit gaps_on = 1'b1;
    int hold_asks = 0;
    int holds_served = 0;
    int hold_left = 0;

    function automatic void clear_walk();
        for (int i = 0; i < 4; i++) win[i] = 8'h00;
        win_fill = 0;
        walk = WALK_HEADER;
        bytes_left = '0;
        pend_flags = 1'b0;
        have_flags = 1'b0;
        end_seen = 1'b0;
        list_pos = 0;
    endfunction

    function automatic void emit(logic [7:0] b);
        edited_t e;
        e = '0;
        e.data = b;
        edited_q.push_back(e);
    endfunction

    function automatic void shift_out();
        emit(win[0]);
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = 8'h00;
        win_fill--;
    endfunction

    function automatic void emit_flags_pair();
        emit(PAIR_ID_LO);
        emit(8'h00);
        emit(PAIR_LEN_LO);
        emit(8'h00);
        emit(PAIR_FLAGS);
        emit(8'h00);
        emit(8'h00);
        emit(8'h00);
    endfunction

    function automatic void edit_byte(list_req_t r);
        logic [15:0] id;
        logic [15:0] len;
        int total;
        logic err;
        edited_t e;
        if (r.first) clear_walk();
        if (win_fill >= 4) shift_out();
        win[win_fill & 3] = r.data;
        win_fill++;
        if (list_pos <= int'(MAX_LIST_BYTES_DEF)) list_pos++;
        case (walk)
            WALK_HEADER: begin
                bytes_left++;
                if (bytes_left >= 4) begin
                    id = {win[1], win[0]};
                    len = {win[3], win[2]};
                    bytes_left = '0;
                    if (id == ID_END) begin
                        walk = WALK_DONE;
                        end_seen = 1'b1;
                        if (!have_flags) emit_flags_pair();
                    end else begin
                        pend_flags = (id == ID_FLAGS && len == LEN_FLAGS);
                        if (len != 0) begin
                            walk = WALK_VALUE;
                            bytes_left = len;
                        end else begin
                            pend_flags = 1'b0;
                        end
                    end
                end
            end
            WALK_VALUE: begin
                bytes_left--;
                if (bytes_left == 0) begin
                    if (pend_flags) begin
                        win[0] = win[0] | MIC_BIT;
                        have_flags = 1'b1;
                        pend_flags = 1'b0;
                    end
                    walk = WALK_HEADER;
                end
            end
            default: ;
        endcase
        if (r.last) begin
            while (win_fill > 0) shift_out();
            if (!end_seen && !have_flags) emit_flags_pair();
            total = list_pos + (have_flags ? 0 : 8);
            err = (list_pos > int'(MAX_LIST_BYTES_DEF)) || (total > int'(cap));
            e = edited_q.pop_back();
            e.last = 1'b1;
            e.err = err;
            e.len = err ? '0 : LEN_W'(total);
            e.ins = !err && !have_flags;
            edited_q.push_back(e);
            clear_walk();
        end
    endfunction

    function automatic void note_bad(string msg);
        n_bad++;
        if (n_bad <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // output side
    always @(negedge i_clk) begin
        if (hold_asks != holds_served) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(99) < 28) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        edited_t got;
        edited_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data = m_axis_tdata[7:0];
            got.last = m_axis_tlast;
            got.err = m_axis_tuser[0];
            got.len = m_axis_tdata[18:8];
            got.ins = m_axis_tuser[1];
            if (edited_q.size() == 0) begin
                note_bad($sformatf("unexpected output byte %02h", got.data));
            end else begin
                want = edited_q.pop_front();
                if (got !== want || m_axis_tdata[23:19] !== 5'b0) begin
                    note_bad($sformatf(
                        "mismatch byte %02h/%02h last %b/%b err %b/%b len %0d/%0d ins %b/%b pad %h",
                        want.data, got.data, want.last, got.last, want.err, got.err,
                        want.len, got.len, want.ins, got.ins, m_axis_tdata[23:19]));
                end
            end
        end
    end

    // input side, entered and left at a falling edge
    task automatic send_req(input list_req_t r);
        while (gaps_on && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r.data;
        s_axis_tuser <= r.first;
        s_axis_tlast <= r.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        edit_byte(r);
        @(negedge i_clk);
    endtask

    task automatic send_all();
        while (pend_reqs.size() != 0) send_req(pend_reqs.pop_front());
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (edited_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_OUT_CAPACITY) cap = val[CAP_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic void add_row(logic [7:0] data, logic first, logic last);
        dir_row_t row;
        row = '0;
        row.req.data = data;
        row.req.first = first;
        row.req.last = last;
        row.cfg = next_cfg;
        row.cap = next_cap;
        next_cfg = 1'b0;
        dir_tab.push_back(row);
    endfunction

    function automatic void set_expect(logic err, logic [LEN_W-1:0] len, logic ins);
        dir_row_t row;
        row = dir_tab.pop_back();
        row.typed = 1'b1;
        row.err = err;
        row.len = len;
        row.ins = ins;
        dir_tab.push_back(row);
    endfunction

    function automatic void fill_body(list_kind_t k);
        int npairs;
        int nval;
        int r;
        logic [15:0] id;
        logic [15:0] len;
        body.delete();
        if (k == LK_NOISE) begin
            nval = $urandom_range(1, 10);
            repeat (nval) body.push_back(8'($urandom));
        end else begin
            npairs = $urandom_range(0, 4);
            repeat (npairs) begin
                r = $urandom_range(99);
                if (r < 40) begin
                    id = ID_FLAGS;
                    len = LEN_FLAGS;
                end else if (r < 50) begin
                    id = ID_FLAGS;
                    len = 16'($urandom_range(0, 6));
                end else if (r < 55) begin
                    id = 16'($urandom);
                    len = 16'($urandom);
                end else begin
                    id = 16'($urandom_range(1, 65535));
                    len = 16'($urandom_range(0, 6));
                end
                nval = (len > 6) ? $urandom_range(0, 8) : int'(len);
                body.push_back(id[7:0]);
                body.push_back(id[15:8]);
                body.push_back(len[7:0]);
                body.push_back(len[15:8]);
                repeat (nval) body.push_back(8'($urandom));
            end
            if (k == LK_ENDED) begin
                len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
                body.push_back(ID_END[7:0]);
                body.push_back(ID_END[15:8]);
                body.push_back(len[7:0]);
                body.push_back(len[15:8]);
                nval = $urandom_range(0, 3);
                repeat (nval) body.push_back(8'($urandom));
            end else if (k == LK_CUT && body.size() > 1) begin
                nval = $urandom_range(1, (body.size() > 3) ? 3 : body.size() - 1);
                repeat (nval) body.delete(body.size() - 1);
            end
        end
        if (body.size() == 0) body.push_back(8'($urandom));
    endfunction

    function automatic void commit_body(logic first, logic keep_open);
        list_req_t req;
        for (int i = 0; i < body.size(); i++) begin
            req.data = body[i];
            req.first = (i == 0) && first;
            req.last = (i == body.size() - 1) && !keep_open;
            pend_reqs.push_back(req);
        end
    endfunction

    function automatic void queue_random_list();
        int r;
        list_kind_t k;
        r = $urandom_range(99);
        if (r < 50) k = LK_ENDED;
        else if (r < 70) k = LK_OPEN_TAIL;
        else if (r < 80) k = LK_CUT;
        else if (r < 90) k = LK_NOISE;
        else k = LK_RESTART;
        if (k == LK_RESTART) begin
            // a list abandoned halfway by a new first byte
            fill_body(LK_ENDED);
            commit_body(1'b1, 1'b1);
            k = LK_ENDED;
        end
        fill_body(k);
        commit_body($urandom_range(9) != 0, 1'b0);
    endfunction

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [CAP_W-1:0] caps [5];
        edited_t e;
        int ph_items;

        cap = CAP_RESET;
        clear_walk();

        // empty list: pair inserted before the end marker
        add_row(8'h00, 1'b1, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b1);
        set_expect(1'b0, 11'd12, 1'b1);
        // complete flags pair gets the mic bit
        add_row(8'h06, 1'b1, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h04, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'hFD, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b1);
        set_expect(1'b0, 11'd12, 1'b0);
        // flags pair cut short by the end of the list
        add_row(8'h06, 1'b1, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h04, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'hAA, 1'b0, 1'b1);
        set_expect(1'b0, 11'd13, 1'b1);
        // restart drops the held byte
        add_row(8'h55, 1'b1, 1'b0);
        add_row(8'h80, 1'b1, 1'b1);
        set_expect(1'b0, 11'd9, 1'b1);
        // no first marker, zero-length pair, walk runs off the end
        add_row(8'hFF, 1'b0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0);
        add_row(8'h00, 1'b0, 1'b1);
        // capacity exceeded
        next_cfg = 1'b1;
        next_cap = '0;
        add_row(8'h7F, 1'b1, 1'b1);
        set_expect(1'b1, 11'd0, 1'b0);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cfg) begin
                settle();
                cfg_write(ADDR_OUT_CAPACITY, 32'(dir_tab[i].cap));
            end
            send_req(dir_tab[i].req);
            if (dir_tab[i].typed) begin
                e = edited_q.pop_back();
                e.err = dir_tab[i].err;
                e.len = dir_tab[i].len;
                e.ins = dir_tab[i].ins;
                edited_q.push_back(e);
            end
        end

        caps[0] = 11'd2047;
        caps[1] = 11'd20;
        caps[2] = 11'($urandom_range(1032));
        caps[3] = CAP_RESET;
        caps[4] = 11'd13;
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            cfg_write(ADDR_OUT_CAPACITY, 32'(caps[ph]));
            gaps_on = (ph != 0);
            if (ph == 0) begin
                // over-long list saturates the byte count
                body.delete();
                repeat (MAX_LIST_BYTES_DEF + 6) body.push_back(8'($urandom));
                commit_body(1'b1, 1'b0);
                send_all();
            end
            if (ph == 1) hold_asks++;
            ph_items = 0;
            while (ph_items < 40) begin
                queue_random_list();
                ph_items += pend_reqs.size();
                send_all();
                if ($urandom_range(9) == 0) settle();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (edited_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_bad == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
